@@ hw/rtl/qlsf_pkg.sv @@
// Shared types and constants of the quadratic least-squares fit core.
package qlsf_pkg;

    localparam int QDepth = 2;
    localparam int QCntW  = $clog2(QDepth + 1);
    localparam int QPtrW  = $clog2(QDepth);

    // Running sums of one point set, as handed from the accumulator to the solver
    typedef struct packed {
        logic [12:0]        n;
        logic signed [23:0] s1;
        logic signed [34:0] s2;
        logic signed [45:0] s3;
        logic signed [56:0] s4;
        logic signed [45:0] t1;
        logic signed [34:0] t2;
        logic signed [23:0] t3;
        logic               dropped;
    } snap_t;

    typedef struct packed {
        logic [31:0] coef_a;
        logic [31:0] coef_b;
        logic [31:0] coef_c;
        logic        singular;
        logic        dropped;
        logic [12:0] used;
    } res_t;

endpackage

@@ hw/rtl/qlsf_front.sv @@
// Point intake: sampling, axis swap, skip test and pipelined sum accumulation.
module qlsf_front #(
    parameter int MAX_POINTS  = 4096,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [11:0]              first_coord,
    input  logic [11:0]              second_coord,
    input  logic                     last_point,
    input  logic                     swap_axes,
    input  logic [qlsf_pkg::QCntW-1:0] q_count,
    output logic                     full,
    output logic                     q_push,
    output qlsf_pkg::snap_t          q_data
);

    localparam logic [12:0] MaxCnt = 13'(MAX_POINTS);

    logic signed [11:0] p_c;
    logic signed [11:0] s_c;
    logic signed [11:0] x_c;
    logic signed [11:0] y_c;
    logic signed [23:0] xx_c;
    logic signed [23:0] xy_c;
    logic               skip_c;

    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic               s1_skip_reg;
    logic signed [11:0] s1_x_reg;
    logic signed [11:0] s1_y_reg;
    logic signed [23:0] s1_xx_reg;
    logic signed [23:0] s1_xy_reg;

    logic signed [35:0] x3_c;
    logic signed [47:0] x4_c;
    logic signed [35:0] x2y_c;
    logic               take_c;
    logic               drop_c;

    qlsf_pkg::snap_t    acc_reg;
    qlsf_pkg::snap_t    acc_next;
    qlsf_pkg::snap_t    upd_c;

    assign p_c    = 12'($signed(first_coord[SAMPLE_BITS-1:0]));
    assign s_c    = 12'($signed(second_coord[SAMPLE_BITS-1:0]));
    assign x_c    = swap_axes ? s_c : p_c;
    assign y_c    = swap_axes ? p_c : s_c;
    assign xx_c   = x_c * x_c;
    assign xy_c   = x_c * y_c;
    assign skip_c = (&first_coord[SAMPLE_BITS-1:0]) | (&second_coord[SAMPLE_BITS-1:0]);

    assign full = (q_count == qlsf_pkg::QCntW'(qlsf_pkg::QDepth))
                || ((q_count == qlsf_pkg::QCntW'(qlsf_pkg::QDepth - 1))
                    && s1_valid_reg && s1_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= last_point;
            s1_skip_reg <= skip_c;
            s1_x_reg    <= x_c;
            s1_y_reg    <= y_c;
            s1_xx_reg   <= xx_c;
            s1_xy_reg   <= xy_c;
        end
    end

    assign x3_c   = s1_xx_reg * s1_x_reg;
    assign x4_c   = s1_xx_reg * s1_xx_reg;
    assign x2y_c  = s1_xx_reg * s1_y_reg;
    assign take_c = s1_valid_reg && !s1_skip_reg && (acc_reg.n < MaxCnt);
    assign drop_c = s1_valid_reg && !s1_skip_reg && !(acc_reg.n < MaxCnt);

    always_comb
    begin
        upd_c = acc_reg;
        if (take_c)
        begin
            upd_c.n  = acc_reg.n + 13'd1;
            upd_c.s1 = acc_reg.s1 + 24'(s1_x_reg);
            upd_c.s2 = acc_reg.s2 + 35'(s1_xx_reg);
            upd_c.s3 = acc_reg.s3 + 46'(x3_c);
            upd_c.s4 = acc_reg.s4 + 57'(x4_c);
            upd_c.t1 = acc_reg.t1 + 46'(x2y_c);
            upd_c.t2 = acc_reg.t2 + 35'(s1_xy_reg);
            upd_c.t3 = acc_reg.t3 + 24'(s1_y_reg);
        end
        upd_c.dropped = acc_reg.dropped | drop_c;
    end

    assign q_push   = s1_valid_reg && s1_last_reg;
    assign q_data   = upd_c;
    assign acc_next = q_push ? '0 : upd_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

@@ hw/rtl/qlsf_queue.sv @@
// Short queue of finished sum snapshots between intake and solver.
module qlsf_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  qlsf_pkg::snap_t            wdata,
    input  logic                       pop,
    output qlsf_pkg::snap_t            head,
    output logic                       empty,
    output logic [qlsf_pkg::QCntW-1:0] count
);

    qlsf_pkg::snap_t                mem [qlsf_pkg::QDepth];
    logic [qlsf_pkg::QPtrW-1:0]     wr_ptr_reg;
    logic [qlsf_pkg::QPtrW-1:0]     rd_ptr_reg;
    logic [qlsf_pkg::QCntW-1:0]     count_reg;
    logic [qlsf_pkg::QCntW-1:0]     count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + qlsf_pkg::QCntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - qlsf_pkg::QCntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == qlsf_pkg::QPtrW'(qlsf_pkg::QDepth - 1))
                            ? '0 : wr_ptr_reg + qlsf_pkg::QPtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == qlsf_pkg::QPtrW'(qlsf_pkg::QDepth - 1))
                            ? '0 : rd_ptr_reg + qlsf_pkg::QPtrW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

@@ hw/rtl/qlsf_solver.sv @@
// Normal-equation solver: shift-add multiply sequencer and restoring divider.
module qlsf_solver (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  qlsf_pkg::snap_t q_head,
    output logic            q_pop,
    input  logic            out_free,
    output logic            res_push,
    output qlsf_pkg::res_t  res
);

    localparam int TW = 136;
    localparam int OW = 72;
    localparam logic [4:0] LastStep = 5'd23;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_DSET = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_DEND = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    typedef enum logic [3:0] {
        OP_N, OP_S1, OP_S2, OP_S3, OP_S4, OP_T1, OP_T2, OP_T3,
        OP_M1, OP_M2, OP_M3, OP_U, OP_V, OP_W
    } opnd_t;

    typedef enum logic [3:0] {
        D_NONE, D_M1, D_M2, D_M3, D_U, D_V, D_W, D_DET, D_NA, D_NB, D_NC
    } dest_t;

    typedef struct packed {
        opnd_t op_a;
        opnd_t op_b;
        logic  sub;
        dest_t dest;
    } step_t;

    function automatic step_t prog(input logic [4:0] idx);
        step_t s;
        unique case (idx)
            5'd0:    s = '{OP_S2, OP_N,  1'b0, D_NONE};
            5'd1:    s = '{OP_S1, OP_S1, 1'b1, D_M1};
            5'd2:    s = '{OP_S3, OP_N,  1'b0, D_NONE};
            5'd3:    s = '{OP_S1, OP_S2, 1'b1, D_M2};
            5'd4:    s = '{OP_S3, OP_S1, 1'b0, D_NONE};
            5'd5:    s = '{OP_S2, OP_S2, 1'b1, D_M3};
            5'd6:    s = '{OP_T2, OP_N,  1'b0, D_NONE};
            5'd7:    s = '{OP_S1, OP_T3, 1'b1, D_U};
            5'd8:    s = '{OP_T2, OP_S1, 1'b0, D_NONE};
            5'd9:    s = '{OP_S2, OP_T3, 1'b1, D_V};
            5'd10:   s = '{OP_S3, OP_T3, 1'b0, D_NONE};
            5'd11:   s = '{OP_T2, OP_S2, 1'b1, D_W};
            5'd12:   s = '{OP_S4, OP_M1, 1'b0, D_NONE};
            5'd13:   s = '{OP_S3, OP_M2, 1'b1, D_NONE};
            5'd14:   s = '{OP_S2, OP_M3, 1'b0, D_DET};
            5'd15:   s = '{OP_T1, OP_M1, 1'b0, D_NONE};
            5'd16:   s = '{OP_S3, OP_U,  1'b1, D_NONE};
            5'd17:   s = '{OP_S2, OP_V,  1'b0, D_NA};
            5'd18:   s = '{OP_S4, OP_U,  1'b0, D_NONE};
            5'd19:   s = '{OP_T1, OP_M2, 1'b1, D_NONE};
            5'd20:   s = '{OP_S2, OP_W,  1'b0, D_NB};
            5'd21:   s = '{OP_S4, OP_V,  1'b1, D_NONE};
            5'd22:   s = '{OP_S3, OP_W,  1'b1, D_NONE};
            5'd23:   s = '{OP_T1, OP_M3, 1'b0, D_NC};
            default: s = '{OP_N,  OP_N,  1'b0, D_NONE};
        endcase
        return s;
    endfunction

    state_t              state_reg;
    state_t              state_next;
    qlsf_pkg::snap_t     snap_reg;
    logic signed [63:0]  m1_reg;
    logic signed [63:0]  m2_reg;
    logic signed [OW-1:0] m3_reg;
    logic signed [63:0]  u_reg;
    logic signed [63:0]  v_reg;
    logic signed [OW-1:0] w_reg;
    logic signed [127:0] det_reg;
    logic signed [127:0] na_reg;
    logic signed [127:0] nb_reg;
    logic signed [127:0] nc_reg;
    logic signed [127:0] acc_reg;
    logic [4:0]          step_reg;
    logic [127:0]        mcand_reg;
    logic [OW-1:0]       mplier_reg;
    logic [127:0]        prod_reg;
    logic                psign_reg;
    logic [1:0]          k_reg;
    logic [TW-1:0]       top_reg;
    logic [TW-1:0]       rem_reg;
    logic [TW-1:0]       dv_reg;
    logic [32:0]         q_reg;
    logic                over_reg;
    logic                neg_reg;
    logic [7:0]          bitcnt_reg;
    logic [31:0]         coef_a_reg;
    logic [31:0]         coef_b_reg;
    logic [31:0]         coef_c_reg;
    logic                sing_reg;

    step_t               cur_c;
    logic signed [OW-1:0] a_val;
    logic signed [OW-1:0] b_val;
    logic [OW-1:0]       a_abs;
    logic [OW-1:0]       b_abs;
    logic signed [127:0] acc_new;
    logic signed [127:0] num_c;
    logic [127:0]        num_abs;
    logic [127:0]        det_abs;
    logic [TW-1:0]       sh_c;
    logic                ge_c;
    logic                ov_c;
    logic [31:0]         m_c;
    logic [31:0]         sat_c;

    function automatic logic signed [OW-1:0] fetch(input opnd_t sel);
        logic signed [OW-1:0] r;
        unique case (sel)
            OP_N:    r = OW'(snap_reg.n);
            OP_S1:   r = OW'(snap_reg.s1);
            OP_S2:   r = OW'(snap_reg.s2);
            OP_S3:   r = OW'(snap_reg.s3);
            OP_S4:   r = OW'(snap_reg.s4);
            OP_T1:   r = OW'(snap_reg.t1);
            OP_T2:   r = OW'(snap_reg.t2);
            OP_T3:   r = OW'(snap_reg.t3);
            OP_M1:   r = OW'(m1_reg);
            OP_M2:   r = OW'(m2_reg);
            OP_M3:   r = m3_reg;
            OP_U:    r = OW'(u_reg);
            OP_V:    r = OW'(v_reg);
            OP_W:    r = w_reg;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign cur_c   = prog(step_reg);
    assign a_val   = fetch(cur_c.op_a);
    assign b_val   = fetch(cur_c.op_b);
    assign a_abs   = a_val[OW-1] ? OW'(-a_val) : OW'(a_val);
    assign b_abs   = b_val[OW-1] ? OW'(-b_val) : OW'(b_val);
    assign acc_new = acc_reg + (psign_reg ? -$signed(prod_reg) : $signed(prod_reg));

    always_comb
    begin
        unique case (k_reg)
            2'd0:    num_c = na_reg;
            2'd1:    num_c = nb_reg;
            default: num_c = nc_reg;
        endcase
    end

    assign num_abs = num_c[127] ? 128'(-num_c) : 128'(num_c);
    assign det_abs = det_reg[127] ? 128'(-det_reg) : 128'(det_reg);

    assign sh_c = {rem_reg[TW-2:0], top_reg[TW-1]};
    assign ge_c = (sh_c >= dv_reg);

    // Saturation to Q16.16 range
    assign ov_c = over_reg | q_reg[32];
    assign m_c  = q_reg[31:0];
    always_comb
    begin
        if (neg_reg)
        begin
            sat_c = (ov_c || m_c > 32'h8000_0000) ? 32'h8000_0000 : 32'd0 - m_c;
        end
        else
        begin
            sat_c = (ov_c || m_c[31]) ? 32'h7FFF_FFFF : m_c;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (!q_empty) state_next = S_LOAD;
            S_LOAD:  state_next = S_MUL;
            S_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    state_next = (step_reg == LastStep) ? S_DSET : S_LOAD;
                end
            end
            S_DSET:  state_next = (det_reg == '0) ? S_OUT : S_DIV;
            S_DIV:   if (bitcnt_reg == '0) state_next = S_DEND;
            S_DEND:  state_next = (k_reg == 2'd2) ? S_OUT : S_DSET;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                snap_reg   <= q_head;
                step_reg   <= '0;
                acc_reg    <= '0;
                k_reg      <= '0;
                coef_a_reg <= '0;
                coef_b_reg <= '0;
                coef_c_reg <= '0;
            end
            S_LOAD:
            begin
                mcand_reg  <= 128'(a_abs);
                mplier_reg <= b_abs;
                prod_reg   <= '0;
                psign_reg  <= a_val[OW-1] ^ b_val[OW-1] ^ cur_c.sub;
            end
            S_MUL:
            begin
                if (mplier_reg != '0)
                begin
                    if (mplier_reg[0])
                    begin
                        prod_reg <= prod_reg + mcand_reg;
                    end
                    mcand_reg  <= {mcand_reg[126:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[OW-1:1]};
                end
                else
                begin
                    acc_reg  <= (cur_c.dest == D_NONE) ? acc_new : '0;
                    step_reg <= step_reg + 5'd1;
                    unique case (cur_c.dest)
                        D_M1:    m1_reg  <= acc_new[63:0];
                        D_M2:    m2_reg  <= acc_new[63:0];
                        D_M3:    m3_reg  <= acc_new[OW-1:0];
                        D_U:     u_reg   <= acc_new[63:0];
                        D_V:     v_reg   <= acc_new[63:0];
                        D_W:     w_reg   <= acc_new[OW-1:0];
                        D_DET:   det_reg <= acc_new;
                        D_NA:    na_reg  <= acc_new;
                        D_NB:    nb_reg  <= acc_new;
                        D_NC:    nc_reg  <= acc_new;
                        default: ;
                    endcase
                end
            end
            S_DSET:
            begin
                sing_reg   <= (det_reg == '0);
                neg_reg    <= num_c[127] ^ det_reg[127];
                top_reg    <= (TW'(num_abs) << 17) + TW'(det_abs);
                dv_reg     <= TW'(det_abs) << 1;
                rem_reg    <= '0;
                q_reg      <= '0;
                over_reg   <= 1'b0;
                bitcnt_reg <= 8'(TW - 1);
            end
            S_DIV:
            begin
                rem_reg    <= ge_c ? sh_c - dv_reg : sh_c;
                top_reg    <= {top_reg[TW-2:0], 1'b0};
                q_reg      <= {q_reg[31:0], ge_c};
                over_reg   <= over_reg | q_reg[32];
                bitcnt_reg <= bitcnt_reg - 8'd1;
            end
            S_DEND:
            begin
                unique case (k_reg)
                    2'd0:    coef_a_reg <= sat_c;
                    2'd1:    coef_b_reg <= sat_c;
                    default: coef_c_reg <= sat_c;
                endcase
                k_reg <= k_reg + 2'd1;
            end
            S_OUT:   ;
            default: ;
        endcase
    end

    assign q_pop        = (state_reg == S_IDLE) && !q_empty;
    assign res_push     = (state_reg == S_OUT) && out_free;
    assign res.coef_a   = coef_a_reg;
    assign res.coef_b   = coef_b_reg;
    assign res.coef_c   = coef_c_reg;
    assign res.singular = sing_reg;
    assign res.dropped  = snap_reg.dropped;
    assign res.used     = snap_reg.n;

endmodule

@@ hw/rtl/quadratic_least_squares_fit_core.sv @@
// Top level of the quadratic least-squares fit core.
// Points: one transfer per cycle while full is low; full rises while two finished point sets
// wait for the solver, or one waits and another is closing in the accumulator. A fit result
// is computed by the bit-serial multiply sequencer (24 products) and the one-bit-a-cycle
// divider (3 quotients).
// Reset clears all sums, the queue pointers, the result valid flag and swap_axes.
module quadratic_least_squares_fit_core #(
    parameter int MAX_POINTS  = 4096,
    parameter int SAMPLE_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [11:0] first_coord,
    input  logic [11:0] second_coord,
    input  logic        last_point,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] coef_quadratic,
    output logic [31:0] coef_linear,
    output logic [31:0] coef_constant,
    output logic        singular,
    output logic        points_dropped,
    output logic [12:0] points_used,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    logic                       swap_axes_reg;
    logic                       accept;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_empty;
    logic [qlsf_pkg::QCntW-1:0] q_count;
    qlsf_pkg::snap_t            q_wdata;
    qlsf_pkg::snap_t            q_head;
    logic                       res_push;
    qlsf_pkg::res_t             res;
    qlsf_pkg::res_t             res_reg;
    logic                       res_valid_reg;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_axes_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            swap_axes_reg <= cfg_wdata;
        end
    end

    qlsf_front #(
        .MAX_POINTS  (MAX_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .first_coord  (first_coord),
        .second_coord (second_coord),
        .last_point   (last_point),
        .swap_axes    (swap_axes_reg),
        .q_count      (q_count),
        .full         (full),
        .q_push       (q_push),
        .q_data       (q_wdata)
    );

    qlsf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .head  (q_head),
        .empty (q_empty),
        .count (q_count)
    );

    qlsf_solver u_solver (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .out_free (!res_valid_reg),
        .res_push (res_push),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_push)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_reg <= res;
        end
    end

    assign empty          = !res_valid_reg;
    assign coef_quadratic = res_reg.coef_a;
    assign coef_linear    = res_reg.coef_b;
    assign coef_constant  = res_reg.coef_c;
    assign singular       = res_reg.singular;
    assign points_dropped = res_reg.dropped;
    assign points_used    = res_reg.used;

endmodule

@@ bench/tb_quadratic_least_squares_fit_core.sv @@
// Testbench of the quadratic least-squares fit core: directed table, random point sets, predictor.
`timescale 1ns / 100ps

module tb_quadratic_least_squares_fit_core;

    localparam int MaxPoints = 4096;
    localparam int FitLatency = 2300;
    localparam int CycleLimit = 3000000;
    localparam logic [11:0] SkipCoord = 12'hFFF;

    typedef struct {
        logic [11:0]    first;
        logic [11:0]    second;
        logic           last;
        logic           typed;
        qlsf_pkg::res_t res;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [11:0] first_coord = '0;
    logic [11:0] second_coord = '0;
    logic        last_point = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] coef_quadratic;
    logic [31:0] coef_linear;
    logic [31:0] coef_constant;
    logic        singular;
    logic        points_dropped;
    logic [12:0] points_used;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;

    qlsf_pkg::res_t fit_expected[$];
    int   fail_count = 0;
    int   cycle_count = 0;
    logic hold_req = 1'b0;

    // predictor state
    logic    axes_swapped = 1'b0;
    int      n_pts = 0;
    longint  sx, sy, sx2, sx3, sx4, sx2y, sxy;
    logic    dropped_seen = 1'b0;

    quadratic_least_squares_fit_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .first_coord   (first_coord),
        .second_coord  (second_coord),
        .last_point    (last_point),
        .empty         (empty),
        .pop           (pop),
        .coef_quadratic(coef_quadratic),
        .coef_linear   (coef_linear),
        .coef_constant (coef_constant),
        .singular      (singular),
        .points_dropped(points_dropped),
        .points_used   (points_used),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("quadratic_least_squares_fit_core: mismatch");
            $finish;
        end
    end

    function automatic logic [31:0] q16_round_sat(logic signed [255:0] num,
                                                  logic signed [255:0] den);
        logic         neg;
        logic [255:0] an;
        logic [255:0] ad;
        logic [255:0] q;
        neg = num[255] ^ den[255];
        an = num[255] ? -num : num;
        ad = den[255] ? -den : den;
        q = (an * 256'd131072 + ad) / (ad << 1);
        if (neg)
        begin
            if (q > 256'h8000_0000)
                return 32'h8000_0000;
            return -q[31:0];
        end
        if (q > 256'h7FFF_FFFF)
            return 32'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic qlsf_pkg::res_t solve_fit();
        logic signed [255:0] n, s1, s2, s3, s4, t1, t2, t3, m1, m2, m3, det, na, nb, nc;
        qlsf_pkg::res_t r;
        n = n_pts; s1 = sx; s2 = sx2; s3 = sx3; s4 = sx4;
        t1 = sx2y; t2 = sxy; t3 = sy;
        m1 = s2 * n - s1 * s1;
        m2 = s3 * n - s1 * s2;
        m3 = s3 * s1 - s2 * s2;
        det = s4 * m1 - s3 * m2 + s2 * m3;
        r = '0;
        if (det == 0)
            r.singular = 1'b1;
        else
        begin
            na = t1 * m1 - s3 * (t2 * n - s1 * t3) + s2 * (t2 * s1 - s2 * t3);
            nb = s4 * (t2 * n - s1 * t3) - t1 * m2 + s2 * (s3 * t3 - t2 * s2);
            nc = s4 * (s2 * t3 - t2 * s1) - s3 * (s3 * t3 - t2 * s2) + t1 * m3;
            r.coef_a = q16_round_sat(na, det);
            r.coef_b = q16_round_sat(nb, det);
            r.coef_c = q16_round_sat(nc, det);
        end
        r.dropped = dropped_seen;
        r.used = n_pts[12:0];
        return r;
    endfunction

    // Returns 1 when the point closes a set, with the fit in r.
    function automatic logic absorb_point(logic [11:0] f, logic [11:0] s, logic last,
                                          output qlsf_pkg::res_t r);
        longint x, y;
        x = axes_swapped ? longint'($signed(s)) : longint'($signed(f));
        y = axes_swapped ? longint'($signed(f)) : longint'($signed(s));
        if (f != SkipCoord && s != SkipCoord)
        begin
            if (n_pts < MaxPoints)
            begin
                sx += x; sy += y; sx2 += x * x; sx3 += x * x * x;
                sx4 += x * x * x * x; sx2y += x * x * y; sxy += x * y;
                n_pts++;
            end
            else
                dropped_seen = 1'b1;
        end
        r = '0;
        if (!last)
            return 1'b0;
        r = solve_fit();
        n_pts = 0;
        sx = 0; sy = 0; sx2 = 0; sx3 = 0; sx4 = 0; sx2y = 0; sxy = 0;
        dropped_seen = 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    task automatic transfer_point(logic [11:0] f, logic [11:0] s, logic last, int gap,
                                  logic typed, qlsf_pkg::res_t typed_res);
        logic acc;
        qlsf_pkg::res_t r;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        first_coord <= f;
        second_coord <= s;
        last_point <= last;
        do
        begin
            @(negedge clk);
            acc = !full;
            @(posedge clk);
        end
        while (!acc);
        if (absorb_point(f, s, last, r))
            fit_expected.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_and_idle();
        push <= 1'b0;
        while (fit_expected.size() != 0)
            @(posedge clk);
        repeat (FitLatency) @(posedge clk);
    endtask

    task automatic write_swap(logic v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        axes_swapped = v;
    endtask

    task automatic send_xy(longint x, longint y, logic last, int gap);
        logic [11:0] f, s;
        f = axes_swapped ? 12'(y) : 12'(x);
        s = axes_swapped ? 12'(x) : 12'(y);
        if ($urandom_range(0, 24) == 0)
        begin
            if ($urandom_range(0, 1)) f = SkipCoord; else s = SkipCoord;
        end
        transfer_point(f, s, last, gap, 1'b0, '0);
    endtask

    task automatic random_sets(int n_items);
        int sent, len, mode, p;
        longint xc;
        sent = 0;
        while (sent < n_items)
        begin
            p = $urandom_range(0, 99);
            len = p < 85 ? $urandom_range(3, 24) : p < 95 ? $urandom_range(1, 2)
                                                          : $urandom_range(25, 120);
            mode = $urandom_range(0, 9);
            xc = longint'($signed(12'($urandom_range(0, 4095))));
            for (int i = 0; i < len; i++)
            begin
                longint x, y;
                y = longint'($signed(12'($urandom_range(0, 4095))));
                if (mode < 6)
                    x = longint'($signed(12'($urandom_range(0, 4095))));
                else if (mode < 9)
                    x = longint'($urandom_range(0, 8)) - 4;
                else
                    x = xc;
                send_xy(x, y, i == len - 1, pick_gap());
            end
            sent += len;
        end
    endtask

    // receive side
    initial
    begin
        logic           got;
        qlsf_pkg::res_t r;
        qlsf_pkg::res_t e;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                for (int i = 0; i < 20000; i++) @(posedge clk);
            end
            else if ($urandom_range(0, 99) < 2)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(50, 400)) @(posedge clk);
            end
            pop <= ($urandom_range(0, 99) < 60);
            @(negedge clk);
            got = pop && !empty;
            r = '{coef_quadratic, coef_linear, coef_constant, singular, points_dropped,
                  points_used};
            if (got)
            begin
                if (fit_expected.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = fit_expected.pop_front();
                    if (r.coef_a !== e.coef_a)
                    begin
                        $error("coef_quadratic exp %h got %h", e.coef_a, r.coef_a);
                        fail_count++;
                    end
                    if (r.coef_b !== e.coef_b)
                    begin
                        $error("coef_linear exp %h got %h", e.coef_b, r.coef_b);
                        fail_count++;
                    end
                    if (r.coef_c !== e.coef_c)
                    begin
                        $error("coef_constant exp %h got %h", e.coef_c, r.coef_c);
                        fail_count++;
                    end
                    if (r.singular !== e.singular)
                    begin
                        $error("singular exp %b got %b", e.singular, r.singular);
                        fail_count++;
                    end
                    if (r.dropped !== e.dropped)
                    begin
                        $error("points_dropped exp %b got %b", e.dropped, r.dropped);
                        fail_count++;
                    end
                    if (r.used !== e.used)
                    begin
                        $error("points_used exp %0d got %0d", e.used, r.used);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        row_t rows[$];
        qlsf_pkg::res_t none;
        none = '0;
        sx = 0; sy = 0; sx2 = 0; sx3 = 0; sx4 = 0; sx2y = 0; sxy = 0;
        rows = '{
            '{12'd5, 12'd7, 1'b1, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 13'd1}},
            '{SkipCoord, 12'd3, 1'b1, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 13'd0}},
            '{12'd0, 12'd0, 1'b0, 1'b0, none},
            '{12'd1, 12'd1, 1'b0, 1'b0, none},
            '{12'd2, 12'd4, 1'b1, 1'b1, '{32'h0001_0000, 32'd0, 32'd0, 1'b0, 1'b0, 13'd3}},
            '{12'h800, 12'h7FF, 1'b0, 1'b0, none},
            '{12'h7FF, 12'h800, 1'b0, 1'b0, none},
            '{12'h000, 12'h800, 1'b0, 1'b0, none},
            '{SkipCoord, 12'd5, 1'b0, 1'b0, none},
            '{12'd100, SkipCoord, 1'b0, 1'b0, none},
            '{12'h800, 12'h800, 1'b1, 1'b0, none},
            '{12'd2045, 12'h800, 1'b0, 1'b0, none},
            '{12'd2046, 12'h7FF, 1'b0, 1'b0, none},
            '{12'd2047, 12'h800, 1'b1, 1'b0, none},
            '{12'h555, 12'hAAA, 1'b0, 1'b0, none},
            '{12'hAAA, 12'h555, 1'b0, 1'b0, none},
            '{12'h2AA, 12'hD55, 1'b0, 1'b0, none},
            '{12'd3, 12'd3, 1'b0, 1'b0, none},
            '{12'd10, 12'd20, 1'b0, 1'b0, none},
            '{12'd7, SkipCoord, 1'b1, 1'b0, none}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_swap(1'b0);
        foreach (rows[i])
            transfer_point(rows[i].first, rows[i].second, rows[i].last, pick_gap(),
                           rows[i].typed, rows[i].res);
        drain_and_idle();

        write_swap(1'b1);
        random_sets(500);
        // pressure: receiver held off while short sets pile up
        push <= 1'b0;
        hold_req <= 1'b1;
        repeat (500) @(posedge clk);
        hold_req <= 1'b0;
        for (int k = 0; k < 30; k++)
            send_xy(longint'($urandom_range(0, 20)) - 10,
                    longint'($urandom_range(0, 100)), (k % 3) == 2, 0);
        drain_and_idle();

        write_swap(1'b0);
        random_sets(500);
        // full count: points beyond the limit are dropped
        for (int k = 0; k < MaxPoints + 4; k++)
            transfer_point(12'($urandom_range(0, 4094)), 12'($urandom_range(0, 4094)),
                           k == MaxPoints + 3, pick_gap() > 10 ? 1 : 0, 1'b0, '0);
        drain_and_idle();

        write_swap(1'b1);
        random_sets(300);
        drain_and_idle();

        if (fail_count == 0)
            $display("quadratic_least_squares_fit_core: match");
        else
            $display("quadratic_least_squares_fit_core: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/qlsf_pkg.sv
hw/rtl/qlsf_front.sv
hw/rtl/qlsf_queue.sv
hw/rtl/qlsf_solver.sv
hw/rtl/quadratic_least_squares_fit_core.sv
bench/tb_quadratic_least_squares_fit_core.sv
